// ===== hdl/srr_pkg.sv =====
// shared types and constants for the selective-repeat receiver
// no dependencies; compile first
package srr_pkg;

  localparam int SEQ_W   = 16;
  localparam int DATA_W  = 32;
  localparam int BYTES_W = 3;
  localparam int KIND_W  = 2;

  localparam logic [BYTES_W-1:0] MAX_BYTES = 3'd4;

  // front queue depth, power of two so the pointers wrap on their own
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK     = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_DELIVER
  } back_state_t;

  // normalized packet as it sits in the front queue
  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [DATA_W-1:0]  data;
    logic [BYTES_W-1:0] bytes;
  } srr_item_t;

  // one ring slot of the reorder store
  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic [BYTES_W-1:0] bytes;
  } slot_t;

endpackage

// ===== hdl/srr_ifs.sv =====
// valid/ready channel interfaces for packets in and results out
// depends on srr_pkg
interface srr_in_if;
  import srr_pkg::*;

  logic               valid;
  logic               ready;
  logic [SEQ_W-1:0]   seq_num;
  logic [DATA_W-1:0]  payload;
  logic [BYTES_W-1:0] byte_count;

  modport source (output valid, seq_num, payload, byte_count, input ready);
  modport sink   (input valid, seq_num, payload, byte_count, output ready);
endinterface

interface srr_out_if;
  import srr_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [SEQ_W-1:0]   seq_out;
  logic [DATA_W-1:0]  data_out;
  logic [BYTES_W-1:0] bytes_out;
  logic               last;

  modport source (output valid, kind, seq_out, data_out, bytes_out, last, input ready);
  modport sink   (input valid, kind, seq_out, data_out, bytes_out, last, output ready);
endinterface

// ===== hdl/srr_front.sv =====
// front end: takes packets, normalizes number, count and word, queues them
// depends on srr_pkg and srr_in_if
module srr_front #(
  parameter int SEQ_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  srr_in_if.sink             in_pkt,
  output srr_pkg::srr_item_t q_item,
  output logic               q_valid,
  input  logic               q_pop
);
  import srr_pkg::*;

  localparam logic [SEQ_W-1:0] SEQ_IN_MASK =
    (SEQ_BITS >= SEQ_W) ? {SEQ_W{1'b1}} : SEQ_W'((32'd1 << SEQ_BITS) - 32'd1);
  localparam logic [QPTR_W:0] QFULL = (QPTR_W+1)'(QDEPTH);

  srr_item_t          q_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]    cnt_r, cnt_nxt;
  logic               push;
  logic [BYTES_W-1:0] cnt_clamp;
  srr_item_t          norm;

  always_comb begin
    cnt_clamp = (in_pkt.byte_count > MAX_BYTES) ? MAX_BYTES : in_pkt.byte_count;
    norm.seq   = in_pkt.seq_num & SEQ_IN_MASK;
    norm.bytes = cnt_clamp;
    // bytes above the count are zeroed before storage
    case (cnt_clamp)
      3'd0:    norm.data = '0;
      3'd1:    norm.data = in_pkt.payload & 32'h0000_00FF;
      3'd2:    norm.data = in_pkt.payload & 32'h0000_FFFF;
      3'd3:    norm.data = in_pkt.payload & 32'h00FF_FFFF;
      default: norm.data = in_pkt.payload;
    endcase
  end

  assign in_pkt.ready = (cnt_r != QFULL);
  assign push         = in_pkt.valid && in_pkt.ready;
  assign q_valid      = (cnt_r != '0);
  assign q_item       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= norm;
    end
  end

endmodule

// ===== hdl/srr_back.sv =====
// back end: window check, reorder store and in-order delivery sequencer
// depends on srr_pkg and srr_out_if
module srr_back #(
  parameter int WINDOW   = 8,
  parameter int SEQ_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  srr_pkg::srr_item_t q_item,
  input  logic               q_valid,
  output logic               q_pop,
  srr_out_if.source          out_res
);
  import srr_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam logic [SEQ_BITS:0]   SEQ_SPAN  = {1'b1, {SEQ_BITS{1'b0}}};
  localparam logic [SEQ_BITS-1:0] WIN_SEQ   = SEQ_BITS'(WINDOW);
  localparam logic [SEQ_BITS-1:0] REACK_LO  = SEQ_BITS'(SEQ_SPAN - (SEQ_BITS+1)'(WINDOW));
  localparam logic [SLOT_W:0]     WIN_SUM   = (SLOT_W+1)'(WINDOW);
  localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(WINDOW - 1);

  back_state_t         state_r, state_nxt;
  logic [SEQ_BITS-1:0] base_r, base_nxt;
  logic [SLOT_W-1:0]   bslot_r, bslot_nxt;
  logic [WINDOW-1:0]   valid_r, valid_nxt;

  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic [SEQ_W-1:0]    out_seq_r, out_seq_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;
  logic [BYTES_W-1:0]  out_bytes_r, out_bytes_nxt;
  logic                out_last_r, out_last_nxt;

  slot_t               slot_mem [WINDOW];
  slot_t               rd_q_r;
  slot_t               wr_data;
  logic                wr_en;

  logic                out_free;
  logic [31:0]         seq_w;
  logic [31:0]         base_w;
  logic [SEQ_BITS-1:0] seq_ext;
  logic [SEQ_BITS-1:0] diff;
  logic                is_reack;
  logic                is_win;
  logic [SLOT_W:0]     slot_sum;
  logic [SLOT_W-1:0]   wr_slot;
  logic [SLOT_W-1:0]   nxt_slot;

  assign out_free = !out_valid_r || out_res.ready;
  assign seq_w    = 32'(q_item.seq);
  assign base_w   = 32'(base_r);
  assign seq_ext  = seq_w[SEQ_BITS-1:0];
  assign diff     = seq_ext - base_r;
  assign is_reack = (diff >= REACK_LO);
  assign is_win   = (diff < WIN_SEQ);

  // ring slot of an in-window number, sum stays below twice the window
  assign slot_sum = {1'b0, bslot_r} + {1'b0, diff[SLOT_W-1:0]};
  assign wr_slot  = (slot_sum >= WIN_SUM) ? SLOT_W'(slot_sum - WIN_SUM) : slot_sum[SLOT_W-1:0];
  assign nxt_slot = (bslot_r == LAST_SLOT) ? '0 : bslot_r + 1'b1;
  assign wr_data  = '{data: q_item.data, bytes: q_item.bytes};

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    bslot_nxt     = bslot_r;
    valid_nxt     = valid_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    out_valid_nxt = out_valid_r && !out_res.ready;
    out_kind_nxt  = out_kind_r;
    out_seq_nxt   = out_seq_r;
    out_data_nxt  = out_data_r;
    out_bytes_nxt = out_bytes_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop         = 1'b1;
          out_valid_nxt = 1'b1;
          out_seq_nxt   = q_item.seq;
          out_data_nxt  = '0;
          out_bytes_nxt = '0;
          out_last_nxt  = 1'b1;
          if (is_reack) begin
            out_kind_nxt = KIND_ACK;
          end else if (is_win) begin
            out_kind_nxt       = KIND_ACK;
            wr_en              = 1'b1;
            valid_nxt[wr_slot] = 1'b1;
            // deliveries follow once the base slot is filled
            if (wr_slot == bslot_r || valid_r[bslot_r]) begin
              out_last_nxt = 1'b0;
              state_nxt    = BK_DELIVER;
            end
          end else begin
            out_kind_nxt = KIND_DISCARD;
          end
        end
      end
      BK_DELIVER: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_kind_nxt       = KIND_DELIVER;
          out_seq_nxt        = base_w[SEQ_W-1:0];
          out_data_nxt       = rd_q_r.data;
          out_bytes_nxt      = rd_q_r.bytes;
          valid_nxt[bslot_r] = 1'b0;
          base_nxt           = base_r + 1'b1;
          bslot_nxt          = nxt_slot;
          out_last_nxt       = !valid_r[nxt_slot];
          if (!valid_r[nxt_slot]) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      base_r      <= '0;
      bslot_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      bslot_r     <= bslot_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_seq_r   <= out_seq_nxt;
    out_data_r  <= out_data_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_last_r  <= out_last_nxt;
  end

  // slot store, read address follows the next base slot, write bypasses the read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_slot] <= wr_data;
    end
    if (wr_en && wr_slot == bslot_nxt) begin
      rd_q_r <= wr_data;
    end else begin
      rd_q_r <= slot_mem[bslot_nxt];
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.kind      = out_kind_r;
  assign out_res.seq_out   = out_seq_r;
  assign out_res.data_out  = out_data_r;
  assign out_res.bytes_out = out_bytes_r;
  assign out_res.last      = out_last_r;

endmodule

// ===== hdl/selective_repeat_receiver.sv =====
// selective-repeat receiver top: front queue feeding the window/delivery back end
// depends on srr_pkg, srr_ifs, srr_front, srr_back
//
//   channel   dir  handshake      beat contents
//   in_pkt    in   valid/ready    seq_num, payload, byte_count
//   out_res   out  valid/ready    kind, seq_out, data_out, bytes_out, last
//
// a packet gets one acknowledge or discard beat from the back end, then one in-order
// delivery beat per cycle while out_res is not held; no new packet is taken meanwhile
// the front holds up to two packets so input keeps flowing while results stall
// an output register drives out_res; a held beat stalls the back end, and the input
// once the front queue is full
// rst_n is synchronous; base, slot valid bits, queue and output valid clear at once
module selective_repeat_receiver #(
  parameter int WINDOW   = 8,
  parameter int SEQ_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  srr_in_if.sink    in_pkt,
  srr_out_if.source out_res
);
  import srr_pkg::*;

  srr_item_t q_item;
  logic      q_valid;
  logic      q_pop;

  srr_front #(
    .SEQ_BITS (SEQ_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pkt  (in_pkt),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  srr_back #(
    .WINDOW   (WINDOW),
    .SEQ_BITS (SEQ_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_res (out_res)
  );

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_discard_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.kind == KIND_DISCARD) |-> out_res.last)
    else $error("discard beat without last");

  a_no_data_unless_delivery: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.kind != KIND_DELIVER) |->
      (out_res.data_out == '0 && out_res.bytes_out == '0))
    else $error("data on a non-delivery beat");

  a_delivery_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.ready && !out_res.last) |=>
      (out_res.valid && out_res.kind == KIND_DELIVER))
    else $error("delivery beat missing after non-last beat");

endmodule
